### src/arxf_pkg.sv
// Shared types, constants and register codes for the ARX model filter.
// Used by the channel interfaces, the register block, controller and datapath.
package arxf_pkg;

   // tap counts are fixed by the register map
   localparam int A_TAPS        = 3;
   localparam int B_TAPS        = 3;
   localparam int MAX_DELAY_DEF = 4;
   localparam int NUM_TAPS      = A_TAPS + B_TAPS;

   localparam int FRAC_BITS  = 13;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int DT_W       = 3;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam int TAP_W   = $clog2(NUM_TAPS);
   localparam int STEP_W  = $clog2(NUM_TAPS + 1);
   localparam int A_IDX_W = (A_TAPS > 1) ? $clog2(A_TAPS) : 1;
   localparam int B_IDX_W = (B_TAPS > 1) ? $clog2(B_TAPS) : 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   // register indexes (byte address / 4)
   typedef enum logic [REG_IDX_W-1:0] {
      REG_A_COEF_0  = 3'd0,
      REG_A_COEF_1  = 3'd1,
      REG_A_COEF_2  = 3'd2,
      REG_B_COEF_0  = 3'd3,
      REG_B_COEF_1  = 3'd4,
      REG_B_COEF_2  = 3'd5,
      REG_DEAD_TIME = 3'd6
   } reg_idx_type;

   typedef struct packed {
      coef_type [A_TAPS-1:0] a_coef;
      coef_type [B_TAPS-1:0] b_coef;
      logic [DT_W-1:0]       dead_time;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic             capture;
      logic             clear_acc;
      logic             mul_en;
      logic [TAP_W-1:0] tap;
      logic             acc_en;
      logic             round_en;
      logic             commit;
   } dp_cmd_type;

endpackage

### src/arxf_req_if.sv
// Request channel: valid/ready handshake carrying one input sample.
// Depends on arxf_pkg.
interface arxf_req_if import arxf_pkg::*; ;
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

### src/arxf_rsp_if.sv
// Result channel: valid/ready handshake carrying one output sample and its clip flag.
// Depends on arxf_pkg.
interface arxf_rsp_if import arxf_pkg::*; ;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       saturated;

   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

### src/arxf_csr.sv
// Configuration registers behind an APB-style port: coefficients and dead time.
// Depends on arxf_pkg.
module arxf_csr import arxf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   // decode write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_A_COEF_0:  cfg_in.a_coef[0]  = pwdata[COEF_W-1:0];
            REG_A_COEF_1:  cfg_in.a_coef[1]  = pwdata[COEF_W-1:0];
            REG_A_COEF_2:  cfg_in.a_coef[2]  = pwdata[COEF_W-1:0];
            REG_B_COEF_0:  cfg_in.b_coef[0]  = pwdata[COEF_W-1:0];
            REG_B_COEF_1:  cfg_in.b_coef[1]  = pwdata[COEF_W-1:0];
            REG_B_COEF_2:  cfg_in.b_coef[2]  = pwdata[COEF_W-1:0];
            REG_DEAD_TIME: cfg_in.dead_time  = pwdata[DT_W-1:0];
            default:       cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         cfg_ff.dead_time <= DT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         REG_A_COEF_0:  prdata = CSR_DATA_W'($unsigned(cfg_ff.a_coef[0]));
         REG_A_COEF_1:  prdata = CSR_DATA_W'($unsigned(cfg_ff.a_coef[1]));
         REG_A_COEF_2:  prdata = CSR_DATA_W'($unsigned(cfg_ff.a_coef[2]));
         REG_B_COEF_0:  prdata = CSR_DATA_W'($unsigned(cfg_ff.b_coef[0]));
         REG_B_COEF_1:  prdata = CSR_DATA_W'($unsigned(cfg_ff.b_coef[1]));
         REG_B_COEF_2:  prdata = CSR_DATA_W'($unsigned(cfg_ff.b_coef[2]));
         REG_DEAD_TIME: prdata = CSR_DATA_W'(cfg_ff.dead_time);
         default:       prdata = '0;
      endcase
   end

endmodule

### src/arxf_ctrl.sv
// Controller state machine: sequences capture, tap-by-tap multiply-accumulate,
// rounding and commit of one request. Depends on arxf_pkg.
module arxf_ctrl import arxf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.tap      = step_ff[TAP_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.clear_acc = 1'b1;
               step_in       = '0;
               state_in      = ST_MAC;
            end
         end
         ST_MAC: begin
            // multiply tap n while accumulating tap n-1
            cmd.mul_en = (step_ff < STEP_W'(NUM_TAPS));
            cmd.acc_en = (step_ff != '0);
            if (step_ff == STEP_W'(NUM_TAPS)) begin
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/arxf_dp.sv
// Datapath: sample histories, one shared multiplier, accumulator, rounding,
// saturation and output register. Depends on arxf_pkg.
module arxf_dp import arxf_pkg::*; #(
   parameter int MAX_DELAY = MAX_DELAY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  dp_cmd_type cmd,
   input  sample_type sample_in,
   output sample_type sample_out,
   output logic       saturated
);

   localparam int HIST_U = MAX_DELAY + B_TAPS - 1;
   localparam int HIDX_W = (HIST_U > 1) ? $clog2(HIST_U) : 1;
   localparam int SEL_W  = $clog2(MAX_DELAY + NUM_TAPS + 1) + 1;
   localparam int Q_W    = ACC_W - FRAC_BITS;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (FRAC_BITS - 1));

   sample_type               cur_sample_ff;
   sample_type               in_hist_ff  [HIST_U];
   sample_type               out_hist_ff [A_TAPS];
   logic [SEL_W-1:0]         dt_ext;
   logic [SEL_W-1:0]         delay_m1;
   logic [SEL_W-1:0]         hist_sel;
   logic [HIDX_W-1:0]        hist_idx;
   logic [TAP_W-1:0]         a_sel;
   coef_type                 mul_coef;
   sample_type               mul_data;
   logic                     mul_neg;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     neg_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  rnd_sum;
   logic signed [Q_W-1:0]    rnd_q;
   sample_type               y_ff;
   logic                     ysat_ff;
   sample_type               sample_out_ff;
   logic                     saturated_ff;

   // clamp dead time to 1..MAX_DELAY and point at the first input tap
   always_comb begin
      dt_ext = SEL_W'(cfg.dead_time);
      if (dt_ext == '0) begin
         delay_m1 = '0;
      end else if (dt_ext > SEL_W'(MAX_DELAY)) begin
         delay_m1 = SEL_W'(MAX_DELAY - 1);
      end else begin
         delay_m1 = dt_ext - SEL_W'(1);
      end
      hist_sel = delay_m1 + SEL_W'(cmd.tap);
      hist_idx = hist_sel[HIDX_W-1:0];
      a_sel    = cmd.tap - TAP_W'(B_TAPS);
   end

   // operand select: input taps first, then output taps (subtracted)
   always_comb begin
      if (cmd.tap < TAP_W'(B_TAPS)) begin
         mul_coef = cfg.b_coef[B_IDX_W'(cmd.tap)];
         mul_data = in_hist_ff[hist_idx];
         mul_neg  = 1'b0;
      end else begin
         mul_coef = cfg.a_coef[a_sel[A_IDX_W-1:0]];
         mul_data = out_hist_ff[a_sel[A_IDX_W-1:0]];
         mul_neg  = 1'b1;
      end
   end

   assign prod_ext = ACC_W'(prod_ff);

   // round half up, then clip to the sample range
   assign rnd_sum = acc_ff + HALF;
   assign rnd_q   = rnd_sum[ACC_W-1:FRAC_BITS];

   // multiply, accumulate, round, output register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_sample_ff <= sample_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_coef) * PROD_W'(mul_data);
         neg_ff  <= mul_neg;
      end
      if (cmd.clear_acc) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= neg_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
      end
      if (cmd.round_en) begin
         if (rnd_q > Q_MAX) begin
            y_ff    <= Q_MAX[SAMPLE_W-1:0];
            ysat_ff <= 1'b1;
         end else if (rnd_q < Q_MIN) begin
            y_ff    <= Q_MIN[SAMPLE_W-1:0];
            ysat_ff <= 1'b1;
         end else begin
            y_ff    <= rnd_q[SAMPLE_W-1:0];
            ysat_ff <= 1'b0;
         end
      end
      if (cmd.commit) begin
         sample_out_ff <= y_ff;
         saturated_ff  <= ysat_ff;
      end
   end

   // advance both histories on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_U; i++) begin
            in_hist_ff[i] <= '0;
         end
         for (int j = 0; j < A_TAPS; j++) begin
            out_hist_ff[j] <= '0;
         end
      end else if (cmd.commit) begin
         for (int i = HIST_U - 1; i > 0; i--) begin
            in_hist_ff[i] <= in_hist_ff[i-1];
         end
         in_hist_ff[0] <= cur_sample_ff;
         for (int j = A_TAPS - 1; j > 0; j--) begin
            out_hist_ff[j] <= out_hist_ff[j-1];
         end
         out_hist_ff[0] <= y_ff;
      end
   end

   assign sample_out = sample_out_ff;
   assign saturated  = saturated_ff;

endmodule

### src/arx_model_filter.sv
// ARX plant model with input dead time. Each request carries one signed 16-bit
// sample and yields one result: the sum of the B weights times the inputs delayed
// by dead_time .. dead_time+2 minus the sum of the A weights times the last three
// outputs, in Q2.13, rounded half up and clipped to 16 bits (saturated flags a
// clip). Histories reset to zero. A dead_time of 0 acts as 1 and one above
// MAX_DELAY as MAX_DELAY. A new request is not taken until the last is committed.
// The single shared multiplier walks the six taps one per cycle, and the last
// product is added in the cycle after; a round step and a commit step follow, and
// the next request is taken in the idle state after the commit. A finished result
// waits in the output register while the next request is taken; a stalled
// result holds the commit.
// Registers sit at byte offsets 4*i on the APB port; write them only while idle.
module arx_model_filter import arxf_pkg::*; #(
   parameter int MAX_DELAY = MAX_DELAY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   arxf_req_if.sink              req_if,
   arxf_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   // configuration registers
   arxf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   arxf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   // arithmetic and histories
   arxf_dp #(
      .MAX_DELAY (MAX_DELAY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sample_in  (req_if.sample_in),
      .sample_out (rsp_if.sample_out),
      .saturated  (rsp_if.saturated)
   );

`ifndef ASSERT_OFF
   // a taken request keeps the block busy for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while previous one still in work");

   // never overwrite a result that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result committed over a pending result");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid after reset");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for arx_model_filter: drives input samples, predicts every
// output sample and clip flag, and programs the APB registers between phases.
// Depends on arxf_pkg, arxf_req_if, arxf_rsp_if and the arx_model_filter RTL.
module tb;
   import arxf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DELAY_MAX   = MAX_DELAY_DEF;
   localparam int HIST_IN     = DELAY_MAX + B_TAPS - 1;
   localparam int DONE_CYCLES = 12;
   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 450;
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      sample_type sample;
      logic       sat;
   } filter_out_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   arxf_req_if req_ch ();
   arxf_rsp_if rsp_ch ();

   // filter mirror: weights, dead time and both histories
   coef_type        a_weight [A_TAPS]  = '{default: '0};
   coef_type        b_weight [B_TAPS]  = '{default: '0};
   logic [DT_W-1:0] lag_cfg            = 3'd1;
   sample_type      y_hist   [A_TAPS]  = '{default: '0};
   sample_type      u_hist   [HIST_IN] = '{default: '0};

   sample_type     pending_samples[$];
   filter_out_type expected_outputs[$];

   int errors       = 0;
   int outputs_seen = 0;
   int stuck_cycles = 0;
   int hold_left    = 0;
   bit hold_done    = 0;
   bit steady       = 0;

   arx_model_filter dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one filter step: weighted sums, round half up, clip, then shift histories
   function automatic filter_out_type filter_step(sample_type u);
      longint         acc;
      longint         y;
      int             lag;
      filter_out_type r;
      if (lag_cfg == 0) lag = 1;
      else if (lag_cfg > DELAY_MAX) lag = DELAY_MAX;
      else lag = lag_cfg;
      acc = 0;
      for (int i = 0; i < B_TAPS; i++)
         acc += longint'(b_weight[i]) * longint'(u_hist[lag - 1 + i]);
      for (int j = 0; j < A_TAPS; j++)
         acc -= longint'(a_weight[j]) * longint'(y_hist[j]);
      y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      r.sat = 1'b0;
      if (y > 32767) begin
         y = 32767;
         r.sat = 1'b1;
      end else if (y < -32768) begin
         y = -32768;
         r.sat = 1'b1;
      end
      r.sample = sample_type'(y);
      for (int j = A_TAPS - 1; j > 0; j--) y_hist[j] = y_hist[j - 1];
      y_hist[0] = r.sample;
      for (int i = HIST_IN - 1; i > 0; i--) u_hist[i] = u_hist[i - 1];
      u_hist[0] = u;
      return r;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return sample_type'(32767);
         1:       return sample_type'(-32768);
         2, 3, 4: return sample_type'(int'($urandom_range(2000)) - 1000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_type pick_coef();
      case ($urandom_range(7))
         0:       return coef_type'(32767);
         1:       return coef_type'(-32768);
         2:       return coef_type'(0);
         3, 4, 5: return coef_type'(int'($urandom_range(6000)) - 3000);
         default: return coef_type'($urandom);
      endcase
   endfunction

   // APB write: setup, access, then mirror the register once it is taken
   task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_A_COEF_0:  a_weight[0] = data[15:0];
         REG_A_COEF_1:  a_weight[1] = data[15:0];
         REG_A_COEF_2:  a_weight[2] = data[15:0];
         REG_B_COEF_0:  b_weight[0] = data[15:0];
         REG_B_COEF_1:  b_weight[1] = data[15:0];
         REG_B_COEF_2:  b_weight[2] = data[15:0];
         REG_DEAD_TIME: lag_cfg     = data[DT_W-1:0];
         default: ;
      endcase
   endtask

   // write every register; upper data bits are random and must be ignored
   task automatic load_filter(coef_type a0, coef_type a1, coef_type a2,
                              coef_type b0, coef_type b1, coef_type b2,
                              logic [DT_W-1:0] lag);
      write_register(REG_A_COEF_0, {16'($urandom), a0});
      write_register(REG_A_COEF_1, {16'($urandom), a1});
      write_register(REG_A_COEF_2, {16'($urandom), a2});
      write_register(REG_B_COEF_0, {16'($urandom), b0});
      write_register(REG_B_COEF_1, {16'($urandom), b1});
      write_register(REG_B_COEF_2, {16'($urandom), b2});
      write_register(REG_DEAD_TIME, {29'($urandom), lag});
   endtask

   // wait until every request is taken and answered, then let the block settle
   task automatic drain();
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || req_ch.valid || expected_outputs.size() != 0);
      repeat (DONE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_samples(sample_type s[$]);
      foreach (s[i]) pending_samples.insert(pending_samples.size(), s[i]);
   endtask

   // request driver: hold the sample until taken, idle at random
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.sample_in <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
            req_ch.valid     <= 1'b1;
            req_ch.sample_in <= pending_samples.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus one long hold-off to back up the filter
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && outputs_seen >= HOLD_AFTER && pending_samples.size() > 20) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_ch.ready <= steady || $urandom_range(99) >= 15;
      end
   end

   // monitor: check each accepted result, predict each accepted request
   always @(posedge clock) begin
      filter_out_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            outputs_seen <= outputs_seen + 1;
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected result sample_out=%0d saturated=%0b",
                        $time, rsp_ch.sample_out, rsp_ch.saturated);
               errors <= errors + 1;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_ch.sample_out !== want.sample || rsp_ch.saturated !== want.sat) begin
                  $display("%0t: mismatch expected sample_out=%0d saturated=%0b, got %0d %0b",
                           $time, want.sample, want.sat, rsp_ch.sample_out, rsp_ch.saturated);
                  errors <= errors + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_outputs.insert(expected_outputs.size(), filter_step(req_ch.sample_in));
      end
   end

   // watchdog: no progress while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (pending_samples.size() == 0 && !req_ch.valid && expected_outputs.size() == 0)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $time, expected_outputs.size());
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample_in = '0;
      rsp_ch.ready     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset weights: everything comes out zero
      queue_samples('{32767, -32768});
      drain();

      // unit weight on the first input tap: output echoes the input a step late
      load_filter(0, 0, 0, 8192, 0, 0, 1);
      queue_samples('{32767, -32768, -1, 0, 12345});
      drain();

      // smallest weight: halves round toward plus infinity
      load_filter(0, 0, 0, 1, 0, 0, 1);
      queue_samples('{4096, -4096, 4095, -4097, -4095, 0});
      drain();

      // extreme weights with dead time zero: clip at both ends of the sample range
      load_filter(-32768, -32768, -32768, 32767, 32767, 32767, 0);
      queue_samples('{32767, 32767, 32767, -32768, -32768, -32768});
      drain();

      // dead time above the maximum, plus a write to an unmapped index
      load_filter(8192, 0, -8192, 8192, -8192, 4096, 7);
      write_register(REG_UNMAPPED, $urandom);
      for (int i = 0; i < 5; i++)
         pending_samples.insert(pending_samples.size(), pick_sample());
      drain();

      // random phases, one per dead-time code; phase 2 runs without idling
      for (int ph = 0; ph < 8; ph++) begin
         steady = (ph == 2);
         load_filter(pick_coef(), pick_coef(), pick_coef(),
                     pick_coef(), pick_coef(), pick_coef(), DT_W'(ph));
         for (int i = 0; i < 100; i++)
            pending_samples.insert(pending_samples.size(), pick_sample());
         drain();
      end

      errors = errors + expected_outputs.size();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### arx_model_filter.f
src/arxf_pkg.sv
src/arxf_req_if.sv
src/arxf_rsp_if.sv
src/arxf_csr.sv
src/arxf_ctrl.sv
src/arxf_dp.sv
src/arx_model_filter.sv
bench/tb.sv
